### rtl/magic_length_frame_deframer_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for magic_length_frame_deframer_top
// Implication checks, sampled on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MAGIC_LENGTH_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define MAGIC_LENGTH_FRAME_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication
`define MLFD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mlfd assertion failed");

// next-cycle implication
`define MLFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mlfd assertion failed");

`endif

### rtl/mlfd_pkg.sv
// ----------------------------------------------------------------------------
// mlfd_pkg
// Types and constants shared by the frame deframer modules.
// ----------------------------------------------------------------------------
package mlfd_pkg;

    localparam int HDR_BYTES = 8;
    localparam int HDR_IDX_W = 3;
    localparam int WORD_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = HDR_IDX_W'(HDR_BYTES - 1);

    localparam logic [WORD_W-1:0] MAGIC_WORD_RESET = 32'h4741_4D45;
    localparam logic [WORD_W-1:0] MAX_LENGTH_RESET = 32'h0010_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAGIC_WORD = 2'd0,
        REG_MAX_LENGTH = 2'd1
    } cfg_reg_t;

    typedef enum logic {
        KIND_PAYLOAD    = 1'b0,
        KIND_BAD_LENGTH = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] payload_byte;
        logic              last;
    } result_t;

    typedef struct packed {
        logic                 in_body;
        logic [HDR_IDX_W-1:0] window_count;
    } status_t;

endpackage

### rtl/mlfd_parser.sv
// ----------------------------------------------------------------------------
// mlfd_parser
// Header hunt window, magic and length check, and payload byte counter.
// ----------------------------------------------------------------------------
module mlfd_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [mlfd_pkg::BYTE_W-1:0]   data_byte,
    input  logic [mlfd_pkg::WORD_W-1:0]   magic_word,
    input  logic [mlfd_pkg::WORD_W-1:0]   max_length,
    output logic                          res_valid,
    output mlfd_pkg::result_t             res,
    output mlfd_pkg::status_t             status
);

    logic [mlfd_pkg::BYTE_W-1:0]    window_reg  [mlfd_pkg::HDR_BYTES-1];
    logic [mlfd_pkg::BYTE_W-1:0]    window_next [mlfd_pkg::HDR_BYTES-1];
    logic [mlfd_pkg::BYTE_W-1:0]    hdr         [mlfd_pkg::HDR_BYTES];
    logic [mlfd_pkg::HDR_IDX_W-1:0] count_reg;
    logic [mlfd_pkg::HDR_IDX_W-1:0] count_next;
    logic                           in_body_reg;
    logic                           in_body_next;
    logic [mlfd_pkg::WORD_W-1:0]    bytes_left_reg;
    logic [mlfd_pkg::WORD_W-1:0]    bytes_left_next;
    logic [mlfd_pkg::WORD_W-1:0]    magic_rx;
    logic [mlfd_pkg::WORD_W-1:0]    length_rx;
    logic                           fin;
    logic                           bad_length;

    always_comb
    begin
        for (int i = 0; i < mlfd_pkg::HDR_BYTES - 1; i++)
        begin
            hdr[i] = window_reg[i];
        end
        hdr[mlfd_pkg::HDR_BYTES-1] = data_byte;
    end

    assign magic_rx   = {hdr[0], hdr[1], hdr[2], hdr[3]};
    assign length_rx  = {hdr[4], hdr[5], hdr[6], hdr[7]};
    assign fin        = (bytes_left_reg <= 32'd1);
    assign bad_length = (length_rx == '0) || (length_rx > max_length);

    always_comb
    begin
        window_next     = window_reg;
        count_next      = count_reg;
        in_body_next    = in_body_reg;
        bytes_left_next = bytes_left_reg;
        res_valid       = 1'b0;
        res.kind        = mlfd_pkg::KIND_PAYLOAD;
        res.payload_byte = '0;
        res.last        = 1'b0;
        if (accept)
        begin
            if (in_body_reg)
            begin
                res_valid        = 1'b1;
                res.payload_byte = data_byte;
                res.last         = fin;
                if (fin)
                begin
                    bytes_left_next = '0;
                    in_body_next    = 1'b0;
                    count_next      = '0;
                end
                else
                begin
                    bytes_left_next = bytes_left_reg - 32'd1;
                end
            end
            else if (count_reg != mlfd_pkg::HDR_LAST_IDX)
            begin
                window_next[count_reg] = data_byte;
                count_next             = count_reg + 1'b1;
            end
            else if (magic_rx != magic_word)
            begin
                // drop the oldest byte
                for (int i = 0; i < mlfd_pkg::HDR_BYTES - 1; i++)
                begin
                    window_next[i] = hdr[i+1];
                end
                count_next = mlfd_pkg::HDR_LAST_IDX;
            end
            else
            begin
                count_next = '0;
                if (bad_length)
                begin
                    res_valid = 1'b1;
                    res.kind  = mlfd_pkg::KIND_BAD_LENGTH;
                end
                else
                begin
                    bytes_left_next = length_rx;
                    in_body_next    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            in_body_reg    <= 1'b0;
            bytes_left_reg <= '0;
        end
        else
        begin
            count_reg      <= count_next;
            in_body_reg    <= in_body_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
    end

    assign status.in_body      = in_body_reg;
    assign status.window_count = count_reg;

endmodule

### rtl/mlfd_out_buf.sv
// ----------------------------------------------------------------------------
// mlfd_out_buf
// Result register with one skid entry between parser and output channel.
// ----------------------------------------------------------------------------
module mlfd_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mlfd_pkg::result_t push_data,
    output logic              space,
    output logic              out_valid,
    input  logic              out_ready,
    output mlfd_pkg::result_t out_data
);

    logic              out_valid_reg;
    logic              out_valid_next;
    mlfd_pkg::result_t out_data_reg;
    mlfd_pkg::result_t out_data_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    mlfd_pkg::result_t skid_data_reg;
    mlfd_pkg::result_t skid_data_next;
    logic              take;

    assign take = out_valid_reg && out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### rtl/magic_length_frame_deframer_top.sv
// A result is shown from the result register; while that register is held, the result waits in the skid entry first.
// Throughput: one byte per cycle while in_ready is high (skid entry empty); the parser state updates in the same cycle.
// A one-entry skid behind the result register keeps input open while a result waits.
// Reset (rst_n low, asynchronous): hunting with an empty window, no result pending,
// magic_word back to "GAME" and max_length back to 1048576.
// ----------------------------------------------------------------------------
// magic_length_frame_deframer_top
// Byte stream deframer: magic-synced header hunt, length check, payload out.
// ----------------------------------------------------------------------------
`include "magic_length_frame_deframer_top_assert.svh"

module magic_length_frame_deframer_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [mlfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mlfd_pkg::WORD_W-1:0]        cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [mlfd_pkg::BYTE_W-1:0]        data_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               kind,
    output logic [mlfd_pkg::BYTE_W-1:0]        payload_byte,
    output logic                               last
);

    logic [mlfd_pkg::WORD_W-1:0] magic_word_reg;
    logic [mlfd_pkg::WORD_W-1:0] magic_word_next;
    logic [mlfd_pkg::WORD_W-1:0] max_length_reg;
    logic [mlfd_pkg::WORD_W-1:0] max_length_next;
    logic                        accept;
    logic                        res_valid;
    mlfd_pkg::result_t           res;
    mlfd_pkg::result_t           out_data;
    mlfd_pkg::status_t           status;

    always_comb
    begin
        magic_word_next = magic_word_reg;
        max_length_next = max_length_reg;
        if (cfg_write_en)
        begin
            case (mlfd_pkg::cfg_reg_t'(cfg_index))
                mlfd_pkg::REG_MAGIC_WORD: magic_word_next = cfg_data;
                mlfd_pkg::REG_MAX_LENGTH: max_length_next = cfg_data;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_word_reg <= mlfd_pkg::MAGIC_WORD_RESET;
            max_length_reg <= mlfd_pkg::MAX_LENGTH_RESET;
        end
        else
        begin
            magic_word_reg <= magic_word_next;
            max_length_reg <= max_length_next;
        end
    end

    assign accept = in_valid && in_ready;

    mlfd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .magic_word (magic_word_reg),
        .max_length (max_length_reg),
        .res_valid  (res_valid),
        .res        (res),
        .status     (status)
    );

    mlfd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign kind         = logic'(out_data.kind);
    assign payload_byte = out_data.payload_byte;
    assign last         = out_data.last;

    `MLFD_ASSERT_SAME(a_bad_len_clean, out_valid && kind, (payload_byte == '0) && !last)
    `MLFD_ASSERT_SAME(a_stall_has_result, !in_ready, out_valid)
    `MLFD_ASSERT_SAME(a_body_empty_window, status.in_body, status.window_count == '0)
    `MLFD_ASSERT_NEXT(a_last_ends_body, accept && status.in_body && res.last, !status.in_body)

endmodule

### verif/mlfd_frame_checker.sv
// ----------------------------------------------------------------------------
// mlfd_frame_checker
// Watches the configuration port and the input and output channels of the deframer,
// tracks the header hunt and the body count, and compares every delivered
// result with the oldest predicted one.
// ----------------------------------------------------------------------------
module mlfd_frame_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [mlfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mlfd_pkg::WORD_W-1:0]    cfg_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [mlfd_pkg::BYTE_W-1:0]    data_byte,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           kind,
    input  logic [mlfd_pkg::BYTE_W-1:0]    payload_byte,
    input  logic                           last,
    output int                             mismatches,
    output int                             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [mlfd_pkg::WORD_W-1:0] magic_word_q;
    logic [mlfd_pkg::WORD_W-1:0] max_length_q;
    logic [mlfd_pkg::BYTE_W-1:0] hdr_win [mlfd_pkg::HDR_BYTES];
    int unsigned                 win_fill;
    bit                          body_mode;
    logic [mlfd_pkg::WORD_W-1:0] body_left;
    mlfd_pkg::result_t           deframed_q [$];
    mlfd_pkg::result_t           want;
    int                          error_total = 0;

    task automatic report_mismatch(input string what,
                                   input logic [mlfd_pkg::WORD_W-1:0] got,
                                   input logic [mlfd_pkg::WORD_W-1:0] exp_val);
        error_total++;
        $display("%0t mlfd_frame_checker: %s got 0x%0h, predicted 0x%0h",
                 $realtime, what, got, exp_val);
    endtask

    task automatic deframe_byte(input logic [mlfd_pkg::BYTE_W-1:0] b);
        bit                          fin;
        mlfd_pkg::result_t           res;
        logic [mlfd_pkg::WORD_W-1:0] len;
        if (body_mode)
        begin
            fin = (body_left <= 1);
            res.kind = mlfd_pkg::KIND_PAYLOAD;
            res.payload_byte = b;
            res.last = fin;
            deframed_q.push_back(res);
            if (fin)
            begin
                body_left = '0;
                body_mode = 1'b0;
                win_fill = 0;
            end
            else
            begin
                body_left = body_left - 1;
            end
        end
        else
        begin
            if (win_fill >= mlfd_pkg::HDR_BYTES)
                win_fill = mlfd_pkg::HDR_BYTES - 1;
            hdr_win[win_fill] = b;
            win_fill++;
            if (win_fill == mlfd_pkg::HDR_BYTES)
            begin
                if ({hdr_win[0], hdr_win[1], hdr_win[2], hdr_win[3]} != magic_word_q)
                begin
                    for (int i = 0; i < mlfd_pkg::HDR_BYTES - 1; i++)
                        hdr_win[i] = hdr_win[i + 1];
                    hdr_win[mlfd_pkg::HDR_BYTES - 1] = '0;
                    win_fill = mlfd_pkg::HDR_BYTES - 1;
                end
                else
                begin
                    len = {hdr_win[4], hdr_win[5], hdr_win[6], hdr_win[7]};
                    win_fill = 0;
                    if (len == 0 || len > max_length_q)
                    begin
                        res.kind = mlfd_pkg::KIND_BAD_LENGTH;
                        res.payload_byte = '0;
                        res.last = 1'b0;
                        deframed_q.push_back(res);
                    end
                    else
                    begin
                        body_left = len;
                        body_mode = 1'b1;
                    end
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_word_q = mlfd_pkg::MAGIC_WORD_RESET;
            max_length_q = mlfd_pkg::MAX_LENGTH_RESET;
            for (int i = 0; i < mlfd_pkg::HDR_BYTES; i++)
                hdr_win[i] = '0;
            win_fill = 0;
            body_mode = 1'b0;
            body_left = '0;
            deframed_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (deframed_q.size() == 0)
                begin
                    report_mismatch("unexpected result, kind",
                                    mlfd_pkg::WORD_W'(kind), '0);
                end
                else
                begin
                    want = deframed_q.pop_front();
                    if (kind !== want.kind)
                        report_mismatch("kind", mlfd_pkg::WORD_W'(kind),
                                        mlfd_pkg::WORD_W'(want.kind));
                    if (payload_byte !== want.payload_byte)
                        report_mismatch("payload_byte", mlfd_pkg::WORD_W'(payload_byte),
                                        mlfd_pkg::WORD_W'(want.payload_byte));
                    if (last !== want.last)
                        report_mismatch("last", mlfd_pkg::WORD_W'(last),
                                        mlfd_pkg::WORD_W'(want.last));
                end
            end
            if (cfg_write_en)
            begin
                case (cfg_index)
                    mlfd_pkg::REG_MAGIC_WORD: magic_word_q = cfg_data;
                    mlfd_pkg::REG_MAX_LENGTH: max_length_q = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                deframe_byte(data_byte);
        end
        mismatches <= error_total;
        outstanding <= deframed_q.size();
    end

endmodule

### verif/tb_magic_length_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// tb_magic_length_frame_deframer_top
// Feeds the deframer a byte stream of headers, payloads, noise and broken
// headers under several magic and length-limit settings and three idling
// mixes; the checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_magic_length_frame_deframer_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 400000;

    localparam logic [mlfd_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [mlfd_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_write_en;
    logic [mlfd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mlfd_pkg::WORD_W-1:0]    cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    logic [mlfd_pkg::BYTE_W-1:0]    data_byte;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic                           kind;
    logic [mlfd_pkg::BYTE_W-1:0]    payload_byte;
    logic                           last;

    int                             mismatches;
    int                             outstanding;
    int                             in_idle_pct = 0;
    int                             out_stall_pct = 0;
    int                             phase_items;
    int                             cycle_count = 0;
    logic [mlfd_pkg::WORD_W-1:0]    cur_magic;
    logic [mlfd_pkg::WORD_W-1:0]    cur_max;

    magic_length_frame_deframer_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .payload_byte (payload_byte),
        .last         (last)
    );

    mlfd_frame_checker frame_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .payload_byte (payload_byte),
        .last         (last),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_magic_length_frame_deframer_top: errors");
            $finish;
        end
    end

    task automatic push_byte(input logic [mlfd_pkg::BYTE_W-1:0] b);
        if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < in_idle_pct);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        phase_items++;
    endtask

    task automatic push_word(input logic [mlfd_pkg::WORD_W-1:0] w);
        for (int i = 0; i < 4; i++)
            push_byte(w[mlfd_pkg::WORD_W - 1 - mlfd_pkg::BYTE_W * i -: mlfd_pkg::BYTE_W]);
    endtask

    // drop valid and hold until every predicted result has drained
    task automatic stop_and_settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [mlfd_pkg::WORD_W-1:0] magic_val,
                                input logic [mlfd_pkg::WORD_W-1:0] limit_val,
                                input bit spare);
        cfg_write_en <= 1'b1;
        cfg_index <= mlfd_pkg::REG_MAGIC_WORD;
        cfg_data <= magic_val;
        @(posedge clk);
        cfg_index <= mlfd_pkg::REG_MAX_LENGTH;
        cfg_data <= limit_val;
        @(posedge clk);
        if (spare)
        begin
            cfg_index <= REG_SPARE_A;
            cfg_data <= $urandom();
            @(posedge clk);
            cfg_index <= REG_SPARE_B;
            cfg_data <= $urandom();
            @(posedge clk);
        end
        cfg_write_en <= 1'b0;
        @(posedge clk);
        cur_magic = magic_val;
        cur_max = limit_val;
    endtask

    function automatic logic [mlfd_pkg::BYTE_W-1:0] noise_byte();
        logic [mlfd_pkg::BYTE_W-1:0] b;
        do
            b = mlfd_pkg::BYTE_W'($urandom_range(255));
        while (b == cur_magic[mlfd_pkg::WORD_W-1 -: mlfd_pkg::BYTE_W]);
        return b;
    endfunction

    function automatic logic [mlfd_pkg::WORD_W-1:0] pick_length(
        input logic [mlfd_pkg::WORD_W-1:0] lim);
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return '0;
        if (roll < 22)
        begin
            if (lim == '1)
                return '0;
            if (roll < 16)
                return lim + 1;
            return $urandom_range(32'hFFFF_FFFF, lim + 1);
        end
        if (lim == 0)
            return $urandom_range(1, 64);
        if (roll < 30 && lim <= 64)
            return lim;
        if (roll < 36)
            return $urandom_range(1, (lim < 64) ? lim : 64);
        return $urandom_range(1, (lim < 16) ? lim : 16);
    endfunction

    task automatic random_sequence();
        int                          roll;
        int                          n;
        logic [mlfd_pkg::WORD_W-1:0] len;
        logic [mlfd_pkg::BYTE_W-1:0] brk;
        roll = $urandom_range(99);
        if (roll < 15)
        begin
            repeat ($urandom_range(1, 6)) push_byte(noise_byte());
        end
        else if (roll < 30)
        begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                push_byte(cur_magic[mlfd_pkg::WORD_W - 1 - mlfd_pkg::BYTE_W * i
                                    -: mlfd_pkg::BYTE_W]);
            do
                brk = noise_byte();
            while (brk == cur_magic[mlfd_pkg::WORD_W - 1 - mlfd_pkg::BYTE_W * n
                                    -: mlfd_pkg::BYTE_W]);
            push_byte(brk);
        end
        else
        begin
            repeat ($urandom_range(0, 3)) push_byte(noise_byte());
            len = pick_length(cur_max);
            push_word(cur_magic);
            push_word(len);
            if (len != 0 && len <= cur_max)
                repeat (len) push_byte(mlfd_pkg::BYTE_W'($urandom_range(255)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = mlfd_pkg::REG_MAGIC_WORD;
        cfg_data = '0;
        in_valid = 1'b0;
        data_byte = '0;
        cur_magic = mlfd_pkg::MAGIC_WORD_RESET;
        cur_max = mlfd_pkg::MAX_LENGTH_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph < 2)
            begin
                in_idle_pct = 38;
                out_stall_pct = 68;
            end
            else if (ph < 4)
            begin
                in_idle_pct = 68;
                out_stall_pct = 38;
            end
            else
            begin
                in_idle_pct = 0;
                out_stall_pct = 0;
            end
            case (ph)
                1: program_regs('0, 32'd1, 1'b0);
                2: program_regs('1, '1, 1'b1);
                3: program_regs($urandom(), '0, 1'b1);
                4: program_regs(mlfd_pkg::MAGIC_WORD_RESET, $urandom_range(2, 40), 1'b0);
                5: program_regs($urandom(), mlfd_pkg::MAX_LENGTH_RESET, 1'b0);
                default: ;
            endcase
            phase_items = 0;
            if (ph == 0)
            begin
                push_word(mlfd_pkg::MAGIC_WORD_RESET);
                push_word('0);
                push_byte(8'hFF);
                push_word(mlfd_pkg::MAGIC_WORD_RESET);
                push_word(32'd2);
                push_byte(8'h00);
                push_byte(8'hFF);
                push_word(mlfd_pkg::MAGIC_WORD_RESET);
                push_word(mlfd_pkg::MAX_LENGTH_RESET + 1);
            end
            while (phase_items < ITEMS_PER_PHASE)
                random_sequence();
            stop_and_settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_magic_length_frame_deframer_top: clean");
        else
            $display("tb_magic_length_frame_deframer_top: errors");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/mlfd_pkg.sv
rtl/mlfd_parser.sv
rtl/mlfd_out_buf.sv
rtl/magic_length_frame_deframer_top.sv
verif/mlfd_frame_checker.sv
verif/tb_magic_length_frame_deframer_top.sv
